[hdl/kit_pkg.sv]
// Shared types and constants for the keyed interval table.
`timescale 1ns / 1ps

package kit_pkg;

   localparam int ENTRIES    = 64;
   localparam int POS_BITS   = 32;
   localparam int KEY_BITS   = 8;
   localparam int VALUE_BITS = 32;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      OP_ADD        = 4'd0,
      OP_REMOVE     = 4'd1,
      OP_CLEAR_KEY  = 4'd2,
      OP_CLEAR_ALL  = 4'd3,
      OP_LOOKUP     = 4'd4,
      OP_LOOKUP_ALL = 4'd5,
      OP_TEXT_INS   = 4'd6,
      OP_TEXT_DEL   = 4'd7,
      OP_MERGE      = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      CMD_HOLD,
      CMD_DROP_RANGE,
      CMD_DROP_KEY,
      CMD_DROP_ALL,
      CMD_TEXT_INS,
      CMD_TEXT_DEL,
      CMD_PACK,
      CMD_INSERT,
      CMD_ROTATE
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACT,
      ST_PACK,
      ST_INSERT,
      ST_SCAN,
      ST_FINISH
   } fsm_type;

   typedef struct packed {
      logic                  valid;
      logic [POS_BITS-1:0]   start;
      logic [POS_BITS-1:0]   stop;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [POS_BITS-1:0] pos_a;
      logic [POS_BITS-1:0] pos_b;
      logic [KEY_BITS-1:0] key;
      entry_type           fresh;
   } cell_ctrl_type;

   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] x,
                                                   input logic [POS_BITS-1:0] y);
      logic [POS_BITS:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      return sum[POS_BITS] ? {POS_BITS{1'b1}} : sum[POS_BITS-1:0];
   endfunction

endpackage

[hdl/kit_cell.sv]
// One slot of the span table chain with its local edit logic.
`timescale 1ns / 1ps

module kit_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  kit_pkg::cell_ctrl_type ctrl,
   input  kit_pkg::entry_type    left_entry,
   input  logic                  left_valid,
   input  logic                  left_lt,
   input  kit_pkg::entry_type    right_entry,
   input  logic                  right_move,
   output kit_pkg::entry_type    entry_q,
   output logic                  lt_out,
   output logic                  move_out
);

   logic                         valid_ff, valid_in;
   kit_pkg::entry_type           data_ff, data_in;
   logic [kit_pkg::POS_BITS-1:0] len;

   assign entry_q  = '{valid: valid_ff, start: data_ff.start, stop: data_ff.stop,
                       key: data_ff.key, value: data_ff.value};
   assign lt_out   = valid_ff && (data_ff.start < ctrl.pos_a);
   assign move_out = !left_valid && valid_ff;
   assign len      = ctrl.pos_b - ctrl.pos_a;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctrl.cmd)
         kit_pkg::CMD_DROP_RANGE: begin
            if (data_ff.key == ctrl.key && data_ff.start < ctrl.pos_b &&
                ctrl.pos_a < data_ff.stop) begin
               valid_in = 1'b0;
            end
         end
         kit_pkg::CMD_DROP_KEY: begin
            if (data_ff.key == ctrl.key) begin
               valid_in = 1'b0;
            end
         end
         kit_pkg::CMD_DROP_ALL: begin
            valid_in = 1'b0;
         end
         kit_pkg::CMD_TEXT_INS: begin
            if (data_ff.start >= ctrl.pos_a) begin
               data_in.start = kit_pkg::sat_add(data_ff.start, ctrl.pos_b);
               data_in.stop  = kit_pkg::sat_add(data_ff.stop, ctrl.pos_b);
            end else if (data_ff.stop > ctrl.pos_a) begin
               data_in.stop = kit_pkg::sat_add(data_ff.stop, ctrl.pos_b);
            end
         end
         kit_pkg::CMD_TEXT_DEL: begin
            if (data_ff.stop > ctrl.pos_a) begin
               if (data_ff.start >= ctrl.pos_b) begin
                  data_in.start = data_ff.start - len;
                  data_in.stop  = data_ff.stop - len;
               end else if (data_ff.start >= ctrl.pos_a && data_ff.stop <= ctrl.pos_b) begin
                  valid_in = 1'b0;
               end else if (data_ff.start < ctrl.pos_a && data_ff.stop > ctrl.pos_b) begin
                  data_in.stop = data_ff.stop - len;
               end else if (data_ff.start < ctrl.pos_a) begin
                  data_in.stop = ctrl.pos_a;
               end else begin
                  data_in.start = ctrl.pos_a;
                  data_in.stop  = data_ff.stop - len;
               end
            end
         end
         kit_pkg::CMD_PACK: begin
            // Holes bubble toward the tail one slot per cycle.
            if (right_move) begin
               valid_in = right_entry.valid;
               data_in  = right_entry;
            end else if (move_out) begin
               valid_in = 1'b0;
            end
         end
         kit_pkg::CMD_INSERT: begin
            if (!lt_out && left_lt) begin
               valid_in = 1'b1;
               data_in  = ctrl.fresh;
            end else if (!left_lt) begin
               valid_in = left_entry.valid;
               data_in  = left_entry;
            end
         end
         kit_pkg::CMD_ROTATE: begin
            valid_in = right_entry.valid;
            data_in  = right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

[hdl/keyed_interval_table.sv]
// Keyed interval table: a chain of span cells with a sequencer at its head.
`timescale 1ns / 1ps
// Sequence: edits run one edit step, a compaction pass over the chain and a result step,
// plus an insert step for an add when a slot is free; text insert needs no compaction;
// lookups walk the chain, then answer; merge walks, then compacts; a rejected or unknown
// request is answered at once. Throughput is one request at a time, set by the walk of the
// cell chain. Lookup-all results come at most one per cycle during the walk; the receiver
// cannot stall them. Reset empties the table; span data is left as is and is never read.

module keyed_interval_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [3:0]                     req_type,
   input  logic [kit_pkg::POS_BITS-1:0]   req_pos_a,
   input  logic [kit_pkg::POS_BITS-1:0]   req_pos_b,
   input  logic [kit_pkg::KEY_BITS-1:0]   req_key_id,
   input  logic [kit_pkg::VALUE_BITS-1:0] req_value_handle,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [kit_pkg::KEY_BITS-1:0]   rsp_out_key,
   output logic [kit_pkg::VALUE_BITS-1:0] rsp_out_value,
   output logic [kit_pkg::POS_BITS-1:0]   rsp_span_start,
   output logic [kit_pkg::POS_BITS-1:0]   rsp_span_end,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_last
);

   localparam int E = kit_pkg::ENTRIES;

   kit_pkg::fsm_type              state_ff, state_in;
   kit_pkg::op_type               op_ff, op_in, req_op;
   logic [kit_pkg::POS_BITS-1:0]  a_ff, a_in, b_ff, b_in;
   logic [kit_pkg::KEY_BITS-1:0]  key_ff, key_in;
   logic [kit_pkg::VALUE_BITS-1:0] val_ff, val_in;
   logic [kit_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   kit_pkg::status_type           status_ff, status_in;
   kit_pkg::entry_type            hold_ff, hold_in;   // lookup hit or pending lookup-all hit
   kit_pkg::entry_type            acc_ff, acc_in;     // merge run head
   logic                          stop_ff, stop_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_last_ff, rsp_last_in;
   kit_pkg::status_type           rsp_status_ff, rsp_status_in;
   kit_pkg::entry_type            rsp_entry_ff, rsp_entry_in;

   kit_pkg::cell_ctrl_type        ctrl;
   kit_pkg::entry_type            cell_q [E];
   kit_pkg::entry_type            tail_entry, head, fresh;
   logic [E-1:0]                  lt_vec, move_vec, valid_vec;
   logic                          bad_range, pack_end, scan_end, considered, merge_hit;

   assign req_op = kit_pkg::op_type'(req_type);
   assign head   = cell_q[0];
   assign busy   = (state_ff != kit_pkg::ST_IDLE);

   // An add or remove with a reversed or empty range, or a text delete with a reversed range, is answered at once.
   always_comb begin
      case (req_op)
         kit_pkg::OP_ADD, kit_pkg::OP_REMOVE: bad_range = (req_pos_a >= req_pos_b);
         kit_pkg::OP_TEXT_DEL:                bad_range = (req_pos_a > req_pos_b);
         default:                             bad_range = 1'b0;
      endcase
   end

   assign pack_end = (cnt_ff == kit_pkg::CNT_BITS'(E - 1));
   assign scan_end = (op_ff == kit_pkg::OP_MERGE) ? (cnt_ff == kit_pkg::CNT_BITS'(E))
                                                  : (cnt_ff == kit_pkg::CNT_BITS'(E - 1));

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kit_pkg::ST_IDLE: begin
            if (start) begin
               if (bad_range) begin
                  state_in = kit_pkg::ST_FINISH;
               end else begin
                  case (req_op)
                     kit_pkg::OP_ADD, kit_pkg::OP_REMOVE, kit_pkg::OP_CLEAR_KEY,
                     kit_pkg::OP_CLEAR_ALL, kit_pkg::OP_TEXT_INS,
                     kit_pkg::OP_TEXT_DEL: state_in = kit_pkg::ST_ACT;
                     kit_pkg::OP_LOOKUP, kit_pkg::OP_LOOKUP_ALL,
                     kit_pkg::OP_MERGE: state_in = kit_pkg::ST_SCAN;
                     default: state_in = kit_pkg::ST_FINISH;
                  endcase
               end
            end
         end
         kit_pkg::ST_ACT: begin
            state_in = (op_ff == kit_pkg::OP_TEXT_INS) ? kit_pkg::ST_FINISH : kit_pkg::ST_PACK;
         end
         kit_pkg::ST_PACK: begin
            if (pack_end) begin
               if (op_ff == kit_pkg::OP_ADD && !cell_q[E-1].valid) begin
                  state_in = kit_pkg::ST_INSERT;
               end else begin
                  state_in = kit_pkg::ST_FINISH;
               end
            end
         end
         kit_pkg::ST_INSERT: begin
            state_in = kit_pkg::ST_FINISH;
         end
         kit_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = (op_ff == kit_pkg::OP_MERGE) ? kit_pkg::ST_PACK : kit_pkg::ST_FINISH;
            end
         end
         kit_pkg::ST_FINISH: begin
            state_in = kit_pkg::ST_IDLE;
         end
         default: begin
            state_in = kit_pkg::ST_IDLE;
         end
      endcase
   end

   // Head-of-chain logic for the walking requests. The chain rotates left, so the head
   // cell sees every span once, in table order.
   assign considered = head.valid && !stop_ff && (head.start <= a_ff);
   assign merge_hit  = acc_ff.valid && (acc_ff.key == key_ff) && head.valid &&
                       (head.key == key_ff) && (head.start <= acc_ff.stop);

   always_comb begin
      tail_entry = head;
      if (op_ff == kit_pkg::OP_MERGE) begin
         if (merge_hit) begin
            tail_entry       = head;
            tail_entry.valid = 1'b0;
         end else begin
            tail_entry = acc_ff;
         end
      end
   end

   assign fresh = '{valid: 1'b1, start: a_ff, stop: b_ff, key: key_ff, value: val_ff};

   // Command to the cell chain.
   always_comb begin
      ctrl       = '{cmd: kit_pkg::CMD_HOLD, pos_a: a_ff, pos_b: b_ff, key: key_ff,
                     fresh: fresh};
      case (state_ff)
         kit_pkg::ST_ACT: begin
            case (op_ff)
               kit_pkg::OP_ADD, kit_pkg::OP_REMOVE: ctrl.cmd = kit_pkg::CMD_DROP_RANGE;
               kit_pkg::OP_CLEAR_KEY:               ctrl.cmd = kit_pkg::CMD_DROP_KEY;
               kit_pkg::OP_CLEAR_ALL:               ctrl.cmd = kit_pkg::CMD_DROP_ALL;
               kit_pkg::OP_TEXT_INS:                ctrl.cmd = kit_pkg::CMD_TEXT_INS;
               kit_pkg::OP_TEXT_DEL:                ctrl.cmd = kit_pkg::CMD_TEXT_DEL;
               default:                             ctrl.cmd = kit_pkg::CMD_HOLD;
            endcase
         end
         kit_pkg::ST_PACK:   ctrl.cmd = kit_pkg::CMD_PACK;
         kit_pkg::ST_INSERT: ctrl.cmd = kit_pkg::CMD_INSERT;
         kit_pkg::ST_SCAN:   ctrl.cmd = kit_pkg::CMD_ROTATE;
         default:            ctrl.cmd = kit_pkg::CMD_HOLD;
      endcase
   end

   // Datapath and result registers.
   always_comb begin
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      hold_in       = hold_ff;
      acc_in        = acc_ff;
      stop_in       = stop_ff;
      cnt_in        = '0;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_status_in = kit_pkg::STAT_OK;
      rsp_entry_in  = '0;

      if ((state_ff == kit_pkg::ST_PACK || state_ff == kit_pkg::ST_SCAN) &&
          state_in == state_ff) begin
         cnt_in = cnt_ff + kit_pkg::CNT_BITS'(1);
      end

      unique case (state_ff)
         kit_pkg::ST_IDLE: begin
            if (start) begin
               op_in         = req_op;
               a_in          = req_pos_a;
               b_in          = req_pos_b;
               key_in        = req_key_id;
               val_in        = req_value_handle;
               status_in     = bad_range ? kit_pkg::STAT_RANGE : kit_pkg::STAT_OK;
               hold_in.valid = 1'b0;
               acc_in.valid  = 1'b0;
               stop_in       = 1'b0;
            end
         end
         kit_pkg::ST_PACK: begin
            if (pack_end && op_ff == kit_pkg::OP_ADD && cell_q[E-1].valid) begin
               status_in = kit_pkg::STAT_FULL;
            end
         end
         kit_pkg::ST_SCAN: begin
            if (head.valid && head.start > a_ff) begin
               stop_in = 1'b1;
            end
            case (op_ff)
               kit_pkg::OP_LOOKUP: begin
                  if (considered && head.key == key_ff) begin
                     hold_in = head;
                  end
               end
               kit_pkg::OP_LOOKUP_ALL: begin
                  if (considered && a_ff < head.stop) begin
                     hold_in = head;
                     if (hold_ff.valid) begin
                        rsp_strobe_in = 1'b1;
                        rsp_found_in  = 1'b1;
                        rsp_entry_in  = hold_ff;
                     end
                  end
               end
               kit_pkg::OP_MERGE: begin
                  if (merge_hit) begin
                     if (head.stop > acc_ff.stop) begin
                        acc_in.stop = head.stop;
                     end
                  end else begin
                     acc_in = head;
                  end
               end
               default: begin
               end
            endcase
         end
         kit_pkg::ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = status_ff;
            if (op_ff == kit_pkg::OP_LOOKUP && status_ff == kit_pkg::STAT_OK) begin
               rsp_found_in = hold_ff.valid && (a_ff < hold_ff.stop);
            end else if (op_ff == kit_pkg::OP_LOOKUP_ALL) begin
               rsp_found_in = hold_ff.valid;
            end
            if (rsp_found_in) begin
               rsp_entry_in = hold_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kit_pkg::ST_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      hold_ff       <= hold_in;
      acc_ff        <= acc_in;
      stop_ff       <= stop_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   // The cell chain. Cell 0 sees a full, always-lower left neighbor; the last cell is fed
   // from the head logic during a walk.
   for (genvar i = 0; i < E; i++) begin : g_cell
      kit_pkg::entry_type l_entry, r_entry;
      logic               l_valid, l_lt, r_move;
      if (i == 0) begin : g_first
         assign l_entry = '0;
         assign l_valid = 1'b1;
         assign l_lt    = 1'b1;
      end else begin : g_mid_l
         assign l_entry = cell_q[i-1];
         assign l_valid = cell_q[i-1].valid;
         assign l_lt    = lt_vec[i-1];
      end
      if (i == E - 1) begin : g_last
         assign r_entry = tail_entry;
         assign r_move  = 1'b0;
      end else begin : g_mid_r
         assign r_entry = cell_q[i+1];
         assign r_move  = move_vec[i+1];
      end
      kit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (l_entry),
         .left_valid  (l_valid),
         .left_lt     (l_lt),
         .right_entry (r_entry),
         .right_move  (r_move),
         .entry_q     (cell_q[i]),
         .lt_out      (lt_vec[i]),
         .move_out    (move_vec[i])
      );
      assign valid_vec[i] = cell_q[i].valid;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_out_key    = rsp_entry_ff.key;
   assign rsp_out_value  = rsp_entry_ff.value;
   assign rsp_span_start = rsp_entry_ff.start;
   assign rsp_span_end   = rsp_entry_ff.stop;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   // The insert step only runs when compaction left a free slot at the tail.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kit_pkg::ST_INSERT) |-> !cell_q[E-1].valid)
      else $error("insert issued into a full table");

   // Between requests the occupied slots form one run from the head.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kit_pkg::ST_IDLE) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
      else $error("span table has a hole while idle");

   // A result that carries a span always reports success.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_found_ff) |-> (rsp_status_ff == kit_pkg::STAT_OK))
      else $error("found result with error status");

   // An accepted request keeps the block busy until its final result goes out.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !(rsp_strobe_ff && rsp_last_ff)))
      else $error("request finished without a busy period");

endmodule

[sim/keyed_interval_table_tb.sv]
// Self-checking testbench for the keyed interval table.
`timescale 1ns / 1ps

module keyed_interval_table_tb;
   import kit_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 3 * ENTRIES + 10;

   typedef logic [POS_BITS-1:0]   pos_t;
   typedef logic [KEY_BITS-1:0]   key_t;
   typedef logic [VALUE_BITS-1:0] val_t;

   typedef struct {
      logic       found;
      key_t       key;
      val_t       value;
      pos_t       s;
      pos_t       e;
      status_type status;
      logic       last;
   } span_result_t;

   typedef struct {
      op_type kind;
      pos_t   a;
      pos_t   b;
      key_t   key;
      val_t   value;
      logic   typed;     // The expected result below is written out by hand.
      span_result_t want;
   } request_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_type = '0;
   pos_t req_pos_a = '0;
   pos_t req_pos_b = '0;
   key_t req_key_id = '0;
   val_t req_value_handle = '0;
   logic rsp_strobe, rsp_found, rsp_last;
   key_t rsp_out_key;
   val_t rsp_out_value;
   pos_t rsp_span_start, rsp_span_end;
   logic [1:0] rsp_status;

   keyed_interval_table i_dut (.*);

   // The predictor's own copy of the span table.
   pos_t tbl_start [ENTRIES];
   pos_t tbl_end   [ENTRIES];
   key_t tbl_key   [ENTRIES];
   val_t tbl_value [ENTRIES];
   int   tbl_count = 0;

   span_result_t pending_results[$];
   int   fail_count = 0;
   int   idle_cycles = 0;
   int   sender_idle_pct = 32;

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic span_result_t plain_result(input status_type st);
      span_result_t r;
      r = '{1'b0, '0, '0, '0, '0, st, 1'b1};
      return r;
   endfunction

   function automatic span_result_t span_at(input int idx, input logic lst);
      span_result_t r;
      r = '{1'b1, tbl_key[idx], tbl_value[idx], tbl_start[idx], tbl_end[idx], STAT_OK, lst};
      return r;
   endfunction

   function automatic void copy_span(input int dst, input int src);
      tbl_start[dst] = tbl_start[src];
      tbl_end[dst]   = tbl_end[src];
      tbl_key[dst]   = tbl_key[src];
      tbl_value[dst] = tbl_value[src];
   endfunction

   // Compacts out spans of one key, optionally only those overlapping [s,e).
   function automatic void drop_spans(input key_t k, input logic ranged,
                                      input pos_t s, input pos_t e);
      int w;
      logic hit;
      w = 0;
      for (int r = 0; r < tbl_count; r++) begin
         hit = tbl_key[r] == k && (!ranged || (tbl_start[r] < e && s < tbl_end[r]));
         if (!hit) begin
            if (w != r) copy_span(w, r);
            w++;
         end
      end
      tbl_count = w;
   endfunction

   function automatic pos_t pos_sat_add(input pos_t x, input pos_t y);
      logic [POS_BITS:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      return sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
   endfunction

   // Applies one request to the table and queues the results it must produce.
   function automatic void predict_spans(input op_type kind, input pos_t a, input pos_t b,
                                         input key_t k, input val_t v);
      int i, w, r, hits;
      pos_t len;
      logic keep;
      case (kind)
         OP_ADD: begin
            if (a >= b) begin
               pending_results.push_back(plain_result(STAT_RANGE));
               return;
            end
            drop_spans(k, 1'b1, a, b);
            if (tbl_count >= ENTRIES) begin
               pending_results.push_back(plain_result(STAT_FULL));
               return;
            end
            i = 0;
            while (i < tbl_count && tbl_start[i] < a) i++;
            for (r = tbl_count; r > i; r--) copy_span(r, r - 1);
            tbl_start[i] = a; tbl_end[i] = b; tbl_key[i] = k; tbl_value[i] = v;
            tbl_count++;
         end
         OP_REMOVE: begin
            if (a >= b) begin
               pending_results.push_back(plain_result(STAT_RANGE));
               return;
            end
            drop_spans(k, 1'b1, a, b);
         end
         OP_CLEAR_KEY: drop_spans(k, 1'b0, '0, '0);
         OP_CLEAR_ALL: tbl_count = 0;
         OP_LOOKUP: begin
            i = 0;
            while (i < tbl_count && tbl_start[i] <= a) i++;
            while (i > 0) begin
               i--;
               if (tbl_key[i] == k) begin
                  if (a < tbl_end[i]) begin
                     pending_results.push_back(span_at(i, 1'b1));
                     return;
                  end
                  break;
               end
            end
         end
         OP_LOOKUP_ALL: begin
            hits = 0;
            for (i = 0; i < tbl_count && tbl_start[i] <= a; i++) begin
               if (a < tbl_end[i]) begin
                  pending_results.push_back(span_at(i, 1'b0));
                  hits++;
               end
            end
            if (hits > 0) begin
               pending_results[$].last = 1'b1;
               return;
            end
         end
         OP_TEXT_INS: begin
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_start[i] >= a) begin
                  tbl_start[i] = pos_sat_add(tbl_start[i], b);
                  tbl_end[i]   = pos_sat_add(tbl_end[i], b);
               end else if (tbl_end[i] > a) begin
                  tbl_end[i] = pos_sat_add(tbl_end[i], b);
               end
            end
         end
         OP_TEXT_DEL: begin
            if (a > b) begin
               pending_results.push_back(plain_result(STAT_RANGE));
               return;
            end
            len = b - a;
            w = 0;
            for (r = 0; r < tbl_count; r++) begin
               keep = 1'b1;
               if (tbl_end[r] > a) begin
                  if (tbl_start[r] >= b) begin
                     tbl_start[r] -= len; tbl_end[r] -= len;
                  end else if (tbl_start[r] >= a && tbl_end[r] <= b) begin
                     keep = 1'b0;
                  end else if (tbl_start[r] < a && tbl_end[r] > b) begin
                     tbl_end[r] -= len;
                  end else if (tbl_start[r] < a) begin
                     tbl_end[r] = a;
                  end else begin
                     tbl_start[r] = a; tbl_end[r] -= len;
                  end
               end
               if (keep) begin
                  if (w != r) copy_span(w, r);
                  w++;
               end
            end
            tbl_count = w;
         end
         OP_MERGE: begin
            w = 0; r = 0;
            while (r < tbl_count) begin
               if (tbl_key[r] != k) begin
                  if (w != r) copy_span(w, r);
                  w++; r++;
               end else begin
                  if (w != r) copy_span(w, r);
                  r++;
                  while (r < tbl_count && tbl_key[r] == k && tbl_start[r] <= tbl_end[w]) begin
                     if (tbl_end[r] > tbl_end[w]) tbl_end[w] = tbl_end[r];
                     r++;
                  end
                  w++;
               end
            end
            tbl_count = w;
         end
         default: ;
      endcase
      pending_results.push_back(plain_result(STAT_OK));
   endfunction

   // Drives one request at the falling edge and holds it until it is taken.
   task automatic send_request(input op_type kind, input pos_t a, input pos_t b,
                               input key_t k, input val_t v);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_type = kind; req_pos_a = a; req_pos_b = b;
      req_key_id = k; req_value_handle = v;
      start = 1'b1;
      do @(posedge clock); while (busy);
      predict_spans(kind, a, b, k, v);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Checks every result strobe against the oldest expectation.
   always @(posedge clock) begin
      span_result_t want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_found !== want.found) report_mismatch("found");
            if (rsp_out_key !== want.key) report_mismatch("out_key");
            if (rsp_out_value !== want.value) report_mismatch("out_value");
            if (rsp_span_start !== want.s) report_mismatch("span_start");
            if (rsp_span_end !== want.e) report_mismatch("span_end");
            if (rsp_status !== want.status) report_mismatch("status");
            if (rsp_last !== want.last) report_mismatch("last");
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a result moves.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("keyed_interval_table regression: fail");
            $finish;
         end
      end
   end

   function automatic request_row_t make_row(input op_type kind, input pos_t a, input pos_t b,
                                             input key_t k, input val_t v);
      request_row_t row;
      row.kind = kind; row.a = a; row.b = b; row.key = k; row.value = v;
      row.typed = 1'b0;
      row.want = plain_result(STAT_OK);
      return row;
   endfunction

   function automatic request_row_t typed_row(input op_type kind, input pos_t a, input pos_t b,
                                              input key_t k, input span_result_t want);
      request_row_t row;
      row = make_row(kind, a, b, k, '0);
      row.typed = 1'b1;
      row.want = want;
      return row;
   endfunction

   // Random request: mostly adds and lookups over a small position window so that
   // spans overlap, touch and share starts; now and then the full 32-bit range.
   task automatic send_random_request();
      op_type kind;
      pos_t a, b;
      key_t k;
      int sel;
      sel = $urandom_range(99);
      if (sel < 35) kind = OP_ADD;
      else if (sel < 45) kind = OP_REMOVE;
      else if (sel < 48) kind = OP_CLEAR_KEY;
      else if (sel < 49) kind = OP_CLEAR_ALL;
      else if (sel < 63) kind = OP_LOOKUP;
      else if (sel < 77) kind = OP_LOOKUP_ALL;
      else if (sel < 85) kind = OP_TEXT_INS;
      else if (sel < 93) kind = OP_TEXT_DEL;
      else kind = OP_MERGE;
      if ($urandom_range(9) == 0) begin
         a = $urandom; b = $urandom;
         k = key_t'($urandom);
      end else begin
         a = $urandom_range(200);
         b = (kind == OP_TEXT_INS) ? pos_t'($urandom_range(20))
                                   : a + pos_t'($urandom_range(40)) - 2;
         k = key_t'($urandom_range(3));
      end
      send_request(kind, a, b, k, $urandom);
   endtask

   initial begin
      request_row_t rows[$];
      request_row_t row;
      span_result_t want;
      int base;

      // An empty table first, then range errors, extremes and every operation.
      rows.push_back(typed_row(OP_LOOKUP, 5, 0, 1, plain_result(STAT_OK)));
      rows.push_back(typed_row(OP_LOOKUP_ALL, 5, 0, 1, plain_result(STAT_OK)));
      rows.push_back(typed_row(OP_ADD, 7, 7, 1, plain_result(STAT_RANGE)));
      rows.push_back(typed_row(OP_ADD, 9, 3, 1, plain_result(STAT_RANGE)));
      rows.push_back(typed_row(OP_REMOVE, 9, 9, 1, plain_result(STAT_RANGE)));
      rows.push_back(typed_row(OP_TEXT_DEL, 9, 3, 1, plain_result(STAT_RANGE)));
      rows.push_back(make_row(OP_ADD, 0, '1, '1, '1));
      want = '{1'b1, '1, '1, '0, '1, STAT_OK, 1'b1};
      rows.push_back(typed_row(OP_LOOKUP, 32'hFFFF_FFFE, 0, '1, want));
      rows.push_back(make_row(OP_ADD, 10, 20, 1, 32'h1111));
      rows.push_back(make_row(OP_ADD, 10, 15, 2, 32'h2222));
      rows.push_back(make_row(OP_ADD, 20, 30, 1, 32'h3333));
      rows.push_back(make_row(OP_ADD, 12, 18, 1, 32'h4444));
      rows.push_back(make_row(OP_LOOKUP_ALL, 12, 0, 0, 0));
      rows.push_back(make_row(OP_LOOKUP, 25, 0, 1, 0));
      rows.push_back(make_row(OP_TEXT_INS, 14, 5, 0, 0));
      rows.push_back(make_row(OP_TEXT_INS, 0, '1, 0, 0));
      rows.push_back(make_row(OP_TEXT_DEL, 11, 11, 0, 0));
      rows.push_back(make_row(OP_TEXT_DEL, 0, 32'hFFFF_FFF0, 0, 0));
      rows.push_back(make_row(OP_CLEAR_ALL, 0, 0, 0, 0));
      rows.push_back(make_row(OP_ADD, 1, 5, 3, 1));
      rows.push_back(make_row(OP_ADD, 5, 9, 3, 2));
      rows.push_back(make_row(OP_ADD, 7, 12, 3, 3));
      rows.push_back(make_row(OP_MERGE, 0, 0, 3, 0));
      rows.push_back(make_row(OP_REMOVE, 0, 100, 3, 0));
      rows.push_back(make_row(OP_CLEAR_KEY, 0, 0, '1, 0));

      repeat (4) @(negedge clock);
      reset = 1'b0;

      foreach (rows[n]) begin
         row = rows[n];
         base = pending_results.size();
         send_request(row.kind, row.a, row.b, row.key, row.value);
         if (row.typed && pending_results.size() == base + 1 &&
             pending_results[base] != row.want)
            report_mismatch($sformatf("predictor disagrees with directed row %0d", n));
      end

      // Fill the table to capacity, then overflow it by one.
      wait_drained();
      for (int n = 0; n <= ENTRIES; n++)
         send_request(OP_ADD, pos_t'(n * 3), pos_t'(n * 3 + 2), key_t'(n % 4), val_t'(n));
      send_request(OP_LOOKUP_ALL, 1, 0, 0, 0);
      send_request(OP_CLEAR_ALL, 0, 0, 0, 0);

      // Random phases: a busy sender, then a lazy one, then back to back.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 87 : 0;
         for (int n = 0; n < 86; n++) begin
            send_random_request();
            if (n == 60) wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("keyed_interval_table regression: pass");
      end else begin
         $display("keyed_interval_table regression: fail");
      end
      $finish;
   end

endmodule
